[rtl/ndobf_pkg.sv]
// Shared types and a constant for the NTP delay and offset burst filter.
// No dependencies; used by the core and by its checker.
`default_nettype none

package ndobf_pkg;

   typedef logic [63:0]        stamp_type;
   typedef logic signed [63:0] fixed_type;

   localparam fixed_type MAX_POS = 64'sh7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

[rtl/ntp_delay_offset_burst_filter_core.sv]
// NTP round-trip delay and clock offset with a burst minimum filter.
// Depends on ndobf_pkg for the word types and the reset value of the minima.
`default_nettype none

// The core takes one word of four 32.32 timestamps per cycle while no result
// is stalled, and returns one result word for each through the result register.
// The first stage registers the two differences T2-T1 and T3-T4; the second
// forms the delay, the halved 65-bit offset sum and the compares against the
// running minima, and loads the result register. A stalled result holds the
// pipeline, and the input stage keeps taking words while the result register
// is free or being emptied. Every BURST_LEN-th result carries burst_done and
// the minima of the burst, after which the minima start over.
module ntp_delay_offset_burst_filter_core #(
   parameter int BURST_LEN = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire  [63:0]             req_t1_origin,
   input  wire  [63:0]             req_t2_server_receive,
   input  wire  [63:0]             req_t3_server_transmit,
   input  wire  [63:0]             req_t4_client_receive,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic signed [63:0]      rsp_sample_delay,
   output logic signed [63:0]      rsp_sample_offset,
   output logic                    rsp_burst_done,
   output logic signed [63:0]      rsp_min_delay,
   output logic signed [63:0]      rsp_min_offset
);

   localparam int CNT_W = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BURST_LEN - 1);

   logic                  s1_valid_ff;
   ndobf_pkg::stamp_type  s1_diff_a_ff;
   ndobf_pkg::stamp_type  s1_diff_b_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   ndobf_pkg::fixed_type  min_delay_ff;
   ndobf_pkg::fixed_type  min_delay_in;
   ndobf_pkg::fixed_type  min_offset_ff;
   ndobf_pkg::fixed_type  min_offset_in;

   logic                  rsp_valid_ff;
   ndobf_pkg::fixed_type  rsp_delay_ff;
   ndobf_pkg::fixed_type  rsp_offset_ff;
   logic                  rsp_done_ff;
   ndobf_pkg::fixed_type  rsp_min_delay_ff;
   ndobf_pkg::fixed_type  rsp_min_offset_ff;

   logic                  advance;
   logic                  accept;
   logic                  last;
   logic [64:0]           offset_sum;
   ndobf_pkg::fixed_type  delay_val;
   ndobf_pkg::fixed_type  offset_val;
   ndobf_pkg::fixed_type  new_min_delay;
   ndobf_pkg::fixed_type  new_min_offset;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign req_stall = s1_valid_ff && !advance;

   // The delay (T4-T1)-(T3-T2) equals (T2-T1)-(T3-T4) modulo 2^64.
   always_comb begin
      delay_val      = $signed(s1_diff_a_ff - s1_diff_b_ff);
      offset_sum     = {s1_diff_a_ff[63], s1_diff_a_ff} + {s1_diff_b_ff[63], s1_diff_b_ff};
      offset_val     = $signed(offset_sum[64:1]);
      new_min_delay  = (delay_val < min_delay_ff) ? delay_val : min_delay_ff;
      new_min_offset = (offset_val < min_offset_ff) ? offset_val : min_offset_ff;
      last           = (count_ff == LAST_CNT);
      if (last) begin
         count_in      = '0;
         min_delay_in  = ndobf_pkg::MAX_POS;
         min_offset_in = ndobf_pkg::MAX_POS;
      end else begin
         count_in      = count_ff + 1'b1;
         min_delay_in  = new_min_delay;
         min_offset_in = new_min_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         min_delay_ff  <= ndobf_pkg::MAX_POS;
         min_offset_ff <= ndobf_pkg::MAX_POS;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff  <= 1'b1;
            count_ff      <= count_in;
            min_delay_ff  <= min_delay_in;
            min_offset_ff <= min_offset_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_diff_a_ff <= req_t2_server_receive - req_t1_origin;
         s1_diff_b_ff <= req_t3_server_transmit - req_t4_client_receive;
      end
      if (advance) begin
         rsp_delay_ff      <= delay_val;
         rsp_offset_ff     <= offset_val;
         rsp_done_ff       <= last;
         rsp_min_delay_ff  <= last ? new_min_delay : '0;
         rsp_min_offset_ff <= last ? new_min_offset : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_delay  = rsp_delay_ff;
   assign rsp_sample_offset = rsp_offset_ff;
   assign rsp_burst_done    = rsp_done_ff;
   assign rsp_min_delay     = rsp_min_delay_ff;
   assign rsp_min_offset    = rsp_min_offset_ff;

endmodule

`default_nettype wire

[rtl/ndobf_checker.sv]
// Port-level checks for the NTP delay and offset burst filter core.
// Depends on ndobf_pkg; bound to ntp_delay_offset_burst_filter_core below.
`default_nettype none

module ndobf_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        rsp_valid,
   input wire                        rsp_stall,
   input wire ndobf_pkg::fixed_type  rsp_sample_delay,
   input wire ndobf_pkg::fixed_type  rsp_sample_offset,
   input wire                        rsp_burst_done,
   input wire ndobf_pkg::fixed_type  rsp_min_delay,
   input wire ndobf_pkg::fixed_type  rsp_min_offset
);

   // A stalled result word must be held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_delay)
         && $stable(rsp_sample_offset) && $stable(rsp_burst_done)
         && $stable(rsp_min_delay) && $stable(rsp_min_offset))
      else $error("result word changed while stalled");

   // Minima are reported only on the word that ends a burst.
   a_min_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_burst_done |-> rsp_min_delay == '0 && rsp_min_offset == '0)
      else $error("minima reported outside the end of a burst");

   // The burst minima include the last sample of the burst.
   a_min_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_burst_done |-> rsp_min_delay <= rsp_sample_delay)
      else $error("burst delay minimum above the final sample");

   a_min_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_burst_done |-> rsp_min_offset <= rsp_sample_offset)
      else $error("burst offset minimum above the final sample");

endmodule

bind ntp_delay_offset_burst_filter_core ndobf_checker u_ndobf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_sample_delay  (rsp_sample_delay),
   .rsp_sample_offset (rsp_sample_offset),
   .rsp_burst_done    (rsp_burst_done),
   .rsp_min_delay     (rsp_min_delay),
   .rsp_min_offset    (rsp_min_offset)
);

`default_nettype wire
